/* design/ghr_pkg.sv */
package ghr_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int ANGLE_MAX    = 25736;

   localparam int POS_W  = 32;
   localparam int ROT_W  = 16;
   localparam int DIFF_W = POS_W + 1;            // goal - pos
   localparam int PROD_W = DIFF_W + ROT_W;       // one matrix term
   localparam int ROTD_W = PROD_W + 2;           // sum of three terms
   localparam int XW     = ROTD_W + 3;           // CORDIC x / y with gain headroom
   localparam int ZW     = 34;                   // Q4.30 angle accumulator
   localparam int SQ_BITS = 33;                  // root bits
   localparam int RADW   = 2 * DIFF_W;           // radicand width
   localparam int REMW   = RADW + 1;
   localparam int IDXW   = 6;
   localparam int ANGLE_W = 16;
   localparam int DIST_W  = 33;
   localparam int RAD_W   = 31;

   localparam int DLY     = SQ_BITS - 1 - CORDIC_STEPS;
   localparam int LATENCY = 3 + SQ_BITS + 1;

   localparam logic signed [ZW-1:0] HALF_PI = 34'sd1686629713;

   localparam int CSR_IDXW = 8;
   localparam logic [CSR_IDXW-1:0] CSR_GOAL_X = 8'd0;
   localparam logic [CSR_IDXW-1:0] CSR_GOAL_Y = 8'd1;
   localparam logic [CSR_IDXW-1:0] CSR_GOAL_Z = 8'd2;
   localparam logic [CSR_IDXW-1:0] CSR_RADIUS = 8'd3;

   typedef struct packed {
      logic          vld;
      logic          zero;
      logic [XW-1:0] x;
      logic [XW-1:0] y;
      logic [ZW-1:0] z;
   } cordic_type;

   typedef struct packed {
      logic               vld;
      logic [REMW-1:0]    rem;
      logic [SQ_BITS-1:0] root;
   } sqrt_type;

   // atan(2^-i) in Q4.30, truncated
   function automatic logic [ZW-1:0] atan_entry(input logic [IDXW-1:0] i);
      logic [ZW-1:0] a;
      unique case (i)
         6'd0:  a = 34'd843314856;
         6'd1:  a = 34'd497837829;
         6'd2:  a = 34'd263043836;
         6'd3:  a = 34'd133525158;
         6'd4:  a = 34'd67021686;
         6'd5:  a = 34'd33543515;
         6'd6:  a = 34'd16775850;
         6'd7:  a = 34'd8388437;
         6'd8:  a = 34'd4194282;
         6'd9:  a = 34'd2097149;
         6'd10: a = 34'd1048575;
         6'd11: a = 34'd524287;
         6'd12: a = 34'd262143;
         6'd13: a = 34'd131071;
         6'd14: a = 34'd65535;
         6'd15: a = 34'd32767;
         6'd16: a = 34'd16383;
         6'd17: a = 34'd8191;
         6'd18: a = 34'd4095;
         6'd19: a = 34'd2047;
         6'd20: a = 34'd1023;
         6'd21: a = 34'd511;
         6'd22: a = 34'd255;
         6'd23: a = 34'd127;
         6'd24: a = 34'd63;
         6'd25: a = 34'd31;
         6'd26: a = 34'd15;
         6'd27: a = 34'd7;
         6'd28: a = 34'd3;
         6'd29: a = 34'd1;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

/* design/goal_heading_and_reach_top.sv */
// Goal heading and reach detector. One item (position and rotation matrix) is
// taken in every clock cycle; busy never rises. Each result is on the rsp_
// ports for one cycle with rsp_valid and is taken at the 37th rising edge
// after the edge that took its start (LATENCY = 37), and must be taken then.
// The figure is three stages of difference, product and sum, the square-root
// chain of one cell per root bit (33) and one output register; the CORDIC
// chain (one cell per step) is padded to match. Goal and radius registers may
// be written only when no item is in flight.
module goal_heading_and_reach_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic signed [ghr_pkg::POS_W-1:0]   req_pos_x,
   input  logic signed [ghr_pkg::POS_W-1:0]   req_pos_y,
   input  logic signed [ghr_pkg::POS_W-1:0]   req_pos_z,
   input  logic signed [ghr_pkg::ROT_W-1:0]   req_rot_00,
   input  logic signed [ghr_pkg::ROT_W-1:0]   req_rot_01,
   input  logic signed [ghr_pkg::ROT_W-1:0]   req_rot_02,
   input  logic signed [ghr_pkg::ROT_W-1:0]   req_rot_10,
   input  logic signed [ghr_pkg::ROT_W-1:0]   req_rot_11,
   input  logic signed [ghr_pkg::ROT_W-1:0]   req_rot_12,
   input  logic signed [ghr_pkg::ROT_W-1:0]   req_rot_20,
   input  logic signed [ghr_pkg::ROT_W-1:0]   req_rot_21,
   input  logic signed [ghr_pkg::ROT_W-1:0]   req_rot_22,
   output logic                               rsp_valid,
   output logic                               rsp_reached,
   output logic [ghr_pkg::DIST_W-1:0]         rsp_distance,
   output logic signed [ghr_pkg::ANGLE_W-1:0] rsp_turn_angle,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ghr_pkg::CSR_IDXW-1:0]       csr_index,
   input  logic [ghr_pkg::POS_W-1:0]          csr_data
);
   import ghr_pkg::*;

   logic [POS_W-1:0] goal_x_ff, goal_y_ff, goal_z_ff;
   logic [RAD_W-1:0] radius_ff;

   logic                     v1_ff, v2_ff, v3_ff;
   logic signed [DIFF_W-1:0] d_ff [3];
   logic signed [DIFF_W-1:0] d_in [3];
   logic signed [ROT_W-1:0]  m_ff [6];
   logic signed [PROD_W-1:0] p_ff [6];
   logic signed [PROD_W-1:0] p_in [6];
   logic signed [RADW-1:0]   sq_ff [2];
   logic signed [RADW-1:0]   sq_in [2];
   logic signed [ROTD_W-1:0] rx_ff, rz_ff, rx_in, rz_in;
   logic [RADW-1:0]          s_ff, s_in;

   cordic_type cord [CORDIC_STEPS+1];
   cordic_type cord0_in, cord0_ff;
   cordic_type zd [DLY+1];
   sqrt_type   sq [SQ_BITS+1];

   logic signed [XW-1:0]  px, py;
   logic signed [ZW:0]    zr, zq;
   logic signed [ANGLE_W-1:0] angle_in;
   logic                  reached_in;

   logic                     rsp_valid_ff, rsp_reached_ff;
   logic [DIST_W-1:0]        rsp_distance_ff;
   logic signed [ANGLE_W-1:0] rsp_turn_angle_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff <= '0;
         goal_y_ff <= '0;
         goal_z_ff <= '0;
         radius_ff <= 31'd16384;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_GOAL_X: goal_x_ff <= csr_data;
            CSR_GOAL_Y: goal_y_ff <= csr_data;
            CSR_GOAL_Z: goal_z_ff <= csr_data;
            CSR_RADIUS: radius_ff <= csr_data[RAD_W-1:0];
            default: ;
         endcase
      end
   end

   // stage 1: difference to goal
   always_comb begin
      d_in[0] = $signed({goal_x_ff[POS_W-1], goal_x_ff})
              - $signed({req_pos_x[POS_W-1], req_pos_x});
      d_in[1] = $signed({goal_y_ff[POS_W-1], goal_y_ff})
              - $signed({req_pos_y[POS_W-1], req_pos_y});
      d_in[2] = $signed({goal_z_ff[POS_W-1], goal_z_ff})
              - $signed({req_pos_z[POS_W-1], req_pos_z});
   end

   always_ff @(posedge clock) begin
      d_ff <= d_in;
      m_ff[0] <= req_rot_00;
      m_ff[1] <= req_rot_01;
      m_ff[2] <= req_rot_02;
      m_ff[3] <= req_rot_20;
      m_ff[4] <= req_rot_21;
      m_ff[5] <= req_rot_22;
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start;
      end
   end

   // stage 2: matrix terms and squares (row 1 never reaches an output)
   always_comb begin
      for (int k = 0; k < 6; k++) begin
         p_in[k] = PROD_W'(m_ff[k]) * PROD_W'(d_ff[k % 3]);
      end
      sq_in[0] = RADW'(d_ff[1]) * RADW'(d_ff[1]);
      sq_in[1] = RADW'(d_ff[2]) * RADW'(d_ff[2]);
   end

   always_ff @(posedge clock) begin
      p_ff  <= p_in;
      sq_ff <= sq_in;
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   // stage 3: rotated x and z, radicand
   always_comb begin
      rx_in = ROTD_W'(p_ff[0]) + ROTD_W'(p_ff[1]) + ROTD_W'(p_ff[2]);
      rz_in = ROTD_W'(p_ff[3]) + ROTD_W'(p_ff[4]) + ROTD_W'(p_ff[5]);
      s_in  = sq_ff[0] + sq_ff[1];
   end

   always_ff @(posedge clock) begin
      rx_ff <= rx_in;
      rz_ff <= rz_in;
      s_ff  <= s_in;
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
   end

   // turn the vector into the right half plane before the CORDIC steps
   always_comb begin
      px = XW'(rx_ff);
      py = -XW'(rz_ff);
      cord0_in.vld  = v3_ff;
      cord0_in.zero = (rx_ff == '0) && (rz_ff == '0);
      cord0_in.x    = px;
      cord0_in.y    = py;
      cord0_in.z    = '0;
      if (px[XW-1]) begin
         if (!py[XW-1]) begin
            cord0_in.x = py;
            cord0_in.y = -px;
            cord0_in.z = HALF_PI;
         end else begin
            cord0_in.x = -py;
            cord0_in.y = px;
            cord0_in.z = -HALF_PI;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cord0_ff <= '0;
      end else begin
         cord0_ff <= cord0_in;
      end
   end

   assign cord[0] = cord0_ff;

   for (genvar k = 1; k <= CORDIC_STEPS; k++) begin : g_cordic
      ghr_cordic_cell u_cell (
         .clock (clock),
         .reset (reset),
         .step  (IDXW'(k - 1)),
         .src   (cord[k-1]),
         .dst   (cord[k])
      );
   end

   // pad the angle path to the square-root latency
   assign zd[0] = cord[CORDIC_STEPS];
   for (genvar k = 1; k <= DLY; k++) begin : g_delay
      cordic_type zd_ff;
      always_ff @(posedge clock) begin
         if (reset) begin
            zd_ff <= '0;
         end else begin
            zd_ff <= zd[k-1];
         end
      end
      assign zd[k] = zd_ff;
   end

   always_comb begin
      sq[0].vld  = v3_ff;
      sq[0].rem  = {1'b0, s_ff};
      sq[0].root = '0;
   end

   for (genvar k = 1; k <= SQ_BITS; k++) begin : g_sqrt
      ghr_sqrt_cell u_cell (
         .clock (clock),
         .reset (reset),
         .step  (IDXW'(SQ_BITS - k)),
         .src   (sq[k-1]),
         .dst   (sq[k])
      );
   end

   // round Q4.30 to Q3.13 and clamp (zero for a zero vector); compare distance with radius
   always_comb begin
      zr = $signed({zd[DLY].z[ZW-1], zd[DLY].z}) + 35'sd65536;
      zq = zr >>> 17;
      if (zd[DLY].zero) begin
         angle_in = '0;
      end else if (zq > 35'sd25736) begin
         angle_in = ANGLE_W'(ANGLE_MAX);
      end else if (zq < -35'sd25736) begin
         angle_in = -ANGLE_W'(ANGLE_MAX);
      end else begin
         angle_in = zq[ANGLE_W-1:0];
      end
      reached_in = sq[SQ_BITS].root < {2'b00, radius_ff};
   end

   always_ff @(posedge clock) begin
      rsp_reached_ff    <= reached_in;
      rsp_distance_ff   <= sq[SQ_BITS].root;
      rsp_turn_angle_ff <= angle_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= sq[SQ_BITS].vld;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_reached    = rsp_reached_ff;
   assign rsp_distance   = rsp_distance_ff;
   assign rsp_turn_angle = rsp_turn_angle_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LATENCY))
      else $error("result without a matching start");

   a_align: assert property (@(posedge clock) disable iff (reset)
      sq[SQ_BITS].vld == zd[DLY].vld)
      else $error("angle and distance paths out of step");

   a_zero_angle: assert property (@(posedge clock) disable iff (reset)
      (zd[DLY].vld && zd[DLY].zero) |=> (rsp_turn_angle == '0))
      else $error("zero vector gave nonzero angle");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_turn_angle <= 16'sd25736 && rsp_turn_angle >= -16'sd25736))
      else $error("angle out of range");

endmodule

/* design/ghr_cordic_cell.sv */
module ghr_cordic_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [ghr_pkg::IDXW-1:0]   step,
   input  ghr_pkg::cordic_type        src,
   output ghr_pkg::cordic_type        dst
);
   import ghr_pkg::*;

   logic signed [XW-1:0] x, y, xs, ys;
   logic signed [ZW-1:0] z, a;
   cordic_type cell_in, cell_ff;

   always_comb begin
      x = $signed(src.x);
      y = $signed(src.y);
      z = $signed(src.z);
      xs = x >>> step;
      ys = y >>> step;
      a = $signed(atan_entry(step));
      cell_in.vld  = src.vld;
      cell_in.zero = src.zero;
      if (!y[XW-1]) begin
         cell_in.x = x + ys;
         cell_in.y = y - xs;
         cell_in.z = z + a;
      end else begin
         cell_in.x = x - ys;
         cell_in.y = y + xs;
         cell_in.z = z - a;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= '0;
      end else begin
         cell_ff <= cell_in;
      end
   end

   assign dst = cell_ff;

endmodule

/* design/ghr_sqrt_cell.sv */
module ghr_sqrt_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [ghr_pkg::IDXW-1:0]   step,
   input  ghr_pkg::sqrt_type          src,
   output ghr_pkg::sqrt_type          dst
);
   import ghr_pkg::*;

   logic [REMW-1:0] trial;
   logic [IDXW:0]   sh_root, sh_bit;
   sqrt_type cell_in, cell_ff;

   // trial = (2*root + 2^step) * 2^step, root holds only bits above step
   always_comb begin
      sh_root = {1'b0, step} + 7'd1;
      sh_bit  = {step, 1'b0};
      trial = ({{(REMW-SQ_BITS){1'b0}}, src.root} << sh_root)
            | ({{(REMW-1){1'b0}}, 1'b1} << sh_bit);
      cell_in = src;
      if (src.rem >= trial) begin
         cell_in.rem  = src.rem - trial;
         cell_in.root = src.root | ({{(SQ_BITS-1){1'b0}}, 1'b1} << step);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= '0;
      end else begin
         cell_ff <= cell_in;
      end
   end

   assign dst = cell_ff;

endmodule
